// ===== rtl/core/sfas_pkg.sv =====
// ----------------------------------------------------------------------------
// sfas_pkg
// types and constants of the seek, flee and arrive steering unit
// ----------------------------------------------------------------------------
package sfas_pkg;

	typedef enum logic [1:0] {
		OP_SEEK   = 2'd0,
		OP_FLEE   = 2'd1,
		OP_ARRIVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_MAX_SPEED = 2'd0,
		REG_PANIC     = 2'd1,
		REG_DECEL     = 2'd2,
		REG_UNUSED    = 2'd3
	} reg_idx_t;

	localparam int unsigned REG_W   = 31;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned DIFF_W  = 33;
	localparam int unsigned SQ_W    = 66;
	localparam int unsigned DIST_W  = 33;
	localparam int unsigned SPD_W   = 31;
	localparam int unsigned NUM_W   = 53;

	localparam logic [REG_W-1:0] MAX_SPEED_RST = 31'd65536;
	localparam logic [REG_W-1:0] PANIC_RST     = 31'd655360;
	localparam logic [REG_W-1:0] DECEL_RST     = 31'd65536;

	typedef struct packed {
		op_t                           op;
		logic [2:0][COORD_W-1:0]       vel;
		logic [2:0][DIFF_W-1:0]        d;
		logic                          far;
		logic [DIST_W-1:0]             dlen;
		logic [SPD_W-1:0]              speed;
	} pipe_t;

endpackage

// ===== rtl/core/seek_flee_arrive_steering.sv =====
// ----------------------------------------------------------------------------
// seek_flee_arrive_steering
// streaming steering force unit: seek, flee and arrive on Q16.16 vectors
// ----------------------------------------------------------------------------
// One item (operation in tuser, position, velocity and target in tdata) gives
// one force item. A new item is taken every cycle unless the output stalls;
// a stall holds the whole pipeline. Items pass the bit-per-stage square root
// (34 stages), the arrive speed divider (32 stages) and three force dividers
// (32 stages). The user must write registers only while idle (not enforced).
module seek_flee_arrive_steering (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [sfas_pkg::REG_W-1:0] cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, tgt_x, tgt_y, tgt_z
	input  logic [287:0]               s_tdata,
	// operation
	input  logic [1:0]                 s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// force_x, force_y, force_z
	output logic [95:0]                m_tdata
);
	import sfas_pkg::*;

	localparam int unsigned RT_N = 33;
	localparam int unsigned DV_N = 31;

	logic [REG_W-1:0] max_speed_q, panic_q, decel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= MAX_SPEED_RST;
			panic_q     <= PANIC_RST;
			decel_q     <= DECEL_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MAX_SPEED: max_speed_q <= cfg_data;
				REG_PANIC:     panic_q     <= cfg_data;
				REG_DECEL:     decel_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic out_v_q;
	logic [95:0] out_q;

	assign en       = !out_v_q || m_tready;
	assign s_tready = en;

	// stage 1: differences
	pipe_t pl_s1;
	logic  v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1.op    <= op_t'(s_tuser);
			pl_s1.far   <= 1'b0;
			pl_s1.dlen  <= '0;
			pl_s1.speed <= '0;
			for (int k = 0; k < 3; k++) begin
				pl_s1.vel[k] <= s_tdata[(3+k)*32 +: 32];
				pl_s1.d[k]   <= {s_tdata[(6+k)*32+31], s_tdata[(6+k)*32 +: 32]}
				              - {s_tdata[k*32+31], s_tdata[k*32 +: 32]};
			end
		end
	end

	// stage 2: squares
	pipe_t pl_s2;
	logic  v_s2;
	logic [2:0][SQ_W-1:0] sq_s2;
	logic [61:0] p2_s2;
	logic [2:0][DIFF_W-1:0] mag1;

	always_comb begin
		for (int k = 0; k < 3; k++)
			mag1[k] = pl_s1.d[k][DIFF_W-1] ? DIFF_W'(-pl_s1.d[k]) : pl_s1.d[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s2 <= pl_s1;
			for (int k = 0; k < 3; k++)
				sq_s2[k] <= SQ_W'(mag1[k] * mag1[k]);
			p2_s2 <= 62'(panic_q * panic_q);
		end
	end

	// square root, one result bit per stage
	pipe_t               rt_pl_s  [RT_N+1];
	logic                rt_v_s   [RT_N+1];
	logic [SQ_W-1:0]     rt_rad_s [RT_N+1];
	logic [34:0]         rt_rem_s [RT_N+1];
	logic [DIST_W-1:0]   rt_res_s [RT_N+1];
	logic [61:0]         rt_p2_s  [RT_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rt_v_s[0] <= 1'b0;
		else if (en) rt_v_s[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_pl_s[0]  <= pl_s2;
			rt_rad_s[0] <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			rt_rem_s[0] <= '0;
			rt_res_s[0] <= '0;
			rt_p2_s[0]  <= p2_s2;
		end
	end

	for (genvar j = 0; j < RT_N; j++) begin : g_rt
		logic [36:0] t;
		logic [36:0] trial;
		logic        ge;
		pipe_t       rt_nx;

		assign t     = {rt_rem_s[j], rt_rad_s[j][SQ_W-1 -: 2]};
		assign trial = {2'b00, rt_res_s[j], 2'b01};
		assign ge    = t >= trial;

		always_comb begin
			rt_nx = rt_pl_s[j];
			if (j == 0)
				rt_nx.far = rt_rad_s[j] > {4'b0, rt_p2_s[j]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v_s[j+1] <= 1'b0;
			else if (en) rt_v_s[j+1] <= rt_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_pl_s[j+1]  <= rt_nx;
				rt_rad_s[j+1] <= {rt_rad_s[j][SQ_W-3:0], 2'b00};
				rt_rem_s[j+1] <= ge ? 35'(t - trial) : t[34:0];
				rt_res_s[j+1] <= {rt_res_s[j][DIST_W-2:0], ge};
				rt_p2_s[j+1]  <= rt_p2_s[j];
			end
		end
	end

	// arrive speed divider
	pipe_t             dv_pl_s   [DV_N+1];
	logic              dv_v_s    [DV_N+1];
	logic [32:0]       dv_den_s  [DV_N+1];
	logic [32:0]       dv_rem_s  [DV_N+1];
	logic [DV_N-1:0]   dv_lo_s   [DV_N+1];
	logic [SPD_W-1:0]  dv_q_s    [DV_N+1];
	logic              dv_ovf_s  [DV_N+1];

	pipe_t            ar_pl_s1;
	logic             ar_v_s1;
	logic [NUM_W-1:0] ar_num_s1;
	logic [32:0]      ar_den_s1;
	pipe_t            ar_nx;

	always_comb begin
		ar_nx      = rt_pl_s[RT_N];
		ar_nx.dlen = rt_res_s[RT_N];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ar_v_s1 <= 1'b0;
		else if (en) ar_v_s1 <= rt_v_s[RT_N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ar_pl_s1      <= ar_nx;
			ar_num_s1     <= NUM_W'({rt_res_s[RT_N], 19'b0})
			               + NUM_W'({rt_res_s[RT_N], 17'b0});
			ar_den_s1     <= {decel_q, 1'b0} + {2'b0, decel_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else if (en) dv_v_s[0] <= ar_v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_pl_s[0]  <= ar_pl_s1;
			dv_den_s[0] <= ar_den_s1;
			dv_rem_s[0] <= {11'b0, ar_num_s1[NUM_W-1:DV_N]};
			dv_lo_s[0]  <= ar_num_s1[DV_N-1:0];
			dv_q_s[0]   <= '0;
			dv_ovf_s[0] <= {11'b0, ar_num_s1[NUM_W-1:DV_N]} >= ar_den_s1;
		end
	end

	for (genvar j = 0; j < DV_N; j++) begin : g_dv
		logic [33:0] t;
		logic        ge;

		assign t  = {dv_rem_s[j], dv_lo_s[j][DV_N-1]};
		assign ge = t >= {1'b0, dv_den_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j+1] <= 1'b0;
			else if (en) dv_v_s[j+1] <= dv_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_pl_s[j+1]  <= dv_pl_s[j];
				dv_den_s[j+1] <= dv_den_s[j];
				dv_rem_s[j+1] <= ge ? 33'(t - {1'b0, dv_den_s[j]}) : t[32:0];
				dv_lo_s[j+1]  <= {dv_lo_s[j][DV_N-2:0], 1'b0};
				dv_q_s[j+1]   <= {dv_q_s[j][SPD_W-2:0], ge};
				dv_ovf_s[j+1] <= dv_ovf_s[j];
			end
		end
	end

	// speed select
	pipe_t pl_sp;
	logic  v_sp;
	pipe_t sp_nx;

	always_comb begin
		sp_nx = dv_pl_s[DV_N];
		if (dv_pl_s[DV_N].op == OP_ARRIVE && !dv_ovf_s[DV_N]
		    && dv_q_s[DV_N] < max_speed_q)
			sp_nx.speed = dv_q_s[DV_N];
		else
			sp_nx.speed = max_speed_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sp <= 1'b0;
		else if (en) v_sp <= dv_v_s[DV_N];
	end

	always_ff @(posedge clk) begin
		if (en) pl_sp <= sp_nx;
	end

	// products
	pipe_t pl_mu;
	logic  v_mu;
	logic [2:0][63:0] prod_mu;
	logic [2:0][DIFF_W-1:0] mag_sp;

	always_comb begin
		for (int k = 0; k < 3; k++)
			mag_sp[k] = pl_sp.d[k][DIFF_W-1] ? DIFF_W'(-pl_sp.d[k]) : pl_sp.d[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_mu <= 1'b0;
		else if (en) v_mu <= v_sp;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_mu <= pl_sp;
			for (int k = 0; k < 3; k++)
				prod_mu[k] <= 64'(mag_sp[k] * pl_sp.speed);
		end
	end

	// force dividers, three lanes
	pipe_t                    dz_pl_s  [DV_N+1];
	logic                     dz_v_s   [DV_N+1];
	logic [2:0][32:0]         dz_rem_s [DV_N+1];
	logic [2:0][DV_N-1:0]     dz_lo_s  [DV_N+1];
	logic [2:0][SPD_W-1:0]    dz_q_s   [DV_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dz_v_s[0] <= 1'b0;
		else if (en) dz_v_s[0] <= v_mu;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dz_pl_s[0] <= pl_mu;
			for (int k = 0; k < 3; k++) begin
				dz_rem_s[0][k] <= prod_mu[k][63:DV_N];
				dz_lo_s[0][k]  <= prod_mu[k][DV_N-1:0];
				dz_q_s[0][k]   <= '0;
			end
		end
	end

	for (genvar j = 0; j < DV_N; j++) begin : g_dz
		logic [2:0][33:0] t;
		logic [2:0]       ge;

		always_comb begin
			for (int k = 0; k < 3; k++) begin
				t[k]  = {dz_rem_s[j][k], dz_lo_s[j][k][DV_N-1]};
				ge[k] = t[k] >= {1'b0, dz_pl_s[j].dlen};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dz_v_s[j+1] <= 1'b0;
			else if (en) dz_v_s[j+1] <= dz_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dz_pl_s[j+1] <= dz_pl_s[j];
				for (int k = 0; k < 3; k++) begin
					dz_rem_s[j+1][k] <= ge[k] ? 33'(t[k] - {1'b0, dz_pl_s[j].dlen})
					                          : t[k][32:0];
					dz_lo_s[j+1][k]  <= {dz_lo_s[j][k][DV_N-2:0], 1'b0};
					dz_q_s[j+1][k]   <= {dz_q_s[j][k][SPD_W-2:0], ge[k]};
				end
			end
		end
	end

	// final force and saturation
	pipe_t pf;
	logic  zero_force, zero_des;
	logic [95:0] force_w;

	assign pf         = dz_pl_s[DV_N];
	assign zero_force = pf.op == OP_NONE || (pf.op == OP_FLEE && pf.far)
	                 || (pf.op == OP_ARRIVE && pf.dlen == '0);
	assign zero_des   = pf.dlen == '0;

	always_comb begin
		logic signed [32:0] des;
		logic signed [33:0] f;
		logic               neg;
		for (int k = 0; k < 3; k++) begin
			neg = pf.d[k][DIFF_W-1] ^ (pf.op == OP_FLEE);
			des = neg ? -$signed({2'b00, dz_q_s[DV_N][k]})
			          : $signed({2'b00, dz_q_s[DV_N][k]});
			if (zero_des)
				des = '0;
			f = 34'(des) - 34'($signed(pf.vel[k]));
			if (zero_force)
				force_w[k*32 +: 32] = '0;
			else if (f > 34'sh0_7FFF_FFFF)
				force_w[k*32 +: 32] = 32'h7FFF_FFFF;
			else if (f < -34'sh0_8000_0000)
				force_w[k*32 +: 32] = 32'h8000_0000;
			else
				force_w[k*32 +: 32] = f[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= dz_v_s[DV_N];
	end

	always_ff @(posedge clk) begin
		if (en) out_q <= force_w;
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

`ifndef SYNTHESIS
	a_stall_only_on_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without an output stall");

	a_zero_decel_clamps: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_v_s[0] && dv_den_s[0] == '0) |-> dv_ovf_s[0])
		else $error("zero deceleration did not select max speed");

	a_pipe_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(dz_v_s[DV_N]))
		else $error("pipeline moved during output stall");
`endif

endmodule
